// ----- rtl/efpd_pkg.sv -----
package efpd_pkg;

  // default sample width at the magnitude front end
  localparam int SAMPLE_BITS_DEF = 16;

  // samples skipped at each end of a record before edges are examined
  localparam int GUARD = 10;

  // field widths
  localparam int COEF_W   = 16;
  localparam int ENV_W    = 18;
  localparam int IDX_W    = 16;
  localparam int DUR_W    = 17;
  localparam int IN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int QUEUE_DEPTH_DEF = 2;

  // packed stream widths
  localparam int S_TDATA_W = 2 * IN_W;
  localparam int M_TDATA_W = ((ENV_W + DUR_W + 7) / 8) * 8;

  localparam logic [ENV_W-1:0] ENV_MAX = '1;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_POLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH  = 3'd4;

  // register reset values
  localparam logic [COEF_W-1:0] FILTER_GAIN_RST    = 16'd4118;
  localparam logic [COEF_W-1:0] FILTER_POLE_RST    = 16'd61545;
  localparam logic [ENV_W-1:0]  HIGH_THRESHOLD_RST = 18'd100;
  localparam logic [ENV_W-1:0]  LOW_THRESHOLD_RST  = 18'd1;
  localparam logic [IDX_W-1:0]  RECORD_LENGTH_RST  = 16'd1024;

  typedef struct packed {
    logic [COEF_W-1:0] filter_gain;
    logic [COEF_W-1:0] filter_pole;
    logic [ENV_W-1:0]  high_threshold;
    logic [ENV_W-1:0]  low_threshold;
    logic [IDX_W-1:0]  record_length;
  } efpd_cfg_t;

endpackage

// ----- rtl/envelope_filter_pulse_duration.sv -----
// Complex envelope detector with a one-pole low-pass filter and pulse-duration
// measurement. Each input transaction carries one complex sample; each output
// transaction carries the filtered envelope, tlast on the last sample of a
// record, and on that sample the stop index minus the start index of the pulse.
// The front end forms the magnitude with a bit-pair square root and takes no
// new sample until the last magnitude has been pushed; that iteration sets the
// sustained rate. A two-entry queue separates it from the back end, which
// filters and tracks edges into an output register and takes the next sample
// only once that register has been read. The user must write configuration
// through the cfg channel only while no sample is in flight; the block itself
// does not enforce this. Indexes beyond the register list are ignored.
module envelope_filter_pulse_duration
  import efpd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,    // re_sample[15:0], im_sample[31:16]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,    // envelope[17:0], pulse_duration[34:18]
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  efpd_cfg_t              cfg;
  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;
  logic [SAMPLE_BITS-1:0] front_mag;
  logic [SAMPLE_BITS-1:0] q_mag;
  logic [ENV_W-1:0]       envelope;
  logic [DUR_W-1:0]       pulse_duration;

  assign cfg_ready = !rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_gain    <= FILTER_GAIN_RST;
      cfg.filter_pole    <= FILTER_POLE_RST;
      cfg.high_threshold <= HIGH_THRESHOLD_RST;
      cfg.low_threshold  <= LOW_THRESHOLD_RST;
      cfg.record_length  <= RECORD_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILTER_GAIN:    cfg.filter_gain    <= cfg_data[COEF_W-1:0];
        CFG_FILTER_POLE:    cfg.filter_pole    <= cfg_data[COEF_W-1:0];
        CFG_HIGH_THRESHOLD: cfg.high_threshold <= cfg_data[ENV_W-1:0];
        CFG_LOW_THRESHOLD:  cfg.low_threshold  <= cfg_data[ENV_W-1:0];
        CFG_RECORD_LENGTH:  cfg.record_length  <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  efpd_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .re_sample (s_tdata[IN_W-1:0]),
    .im_sample (s_tdata[2*IN_W-1:IN_W]),
    .push      (q_push),
    .full      (q_full),
    .mag       (front_mag)
  );

  efpd_queue #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (front_mag),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_mag),
    .empty   (q_empty)
  );

  efpd_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .empty          (q_empty),
    .mag            (q_mag),
    .pop            (q_pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .envelope       (envelope),
    .record_end     (m_tlast),
    .pulse_duration (pulse_duration)
  );

  assign m_tdata = M_TDATA_W'({pulse_duration, envelope});

endmodule

// ----- rtl/efpd_front.sv -----
module efpd_front
  import efpd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [IN_W-1:0] re_sample,
  input  logic signed [IN_W-1:0] im_sample,
  output logic                   push,
  input  logic                   full,
  output logic [SAMPLE_BITS-1:0] mag
);

  localparam int SB    = SAMPLE_BITS;
  localparam int EXT_W = (SB > IN_W) ? SB : IN_W;
  localparam int RAD_W = 2 * SB;
  localparam int REM_W = SB + 1;
  localparam int CNT_W = (SB > 1) ? $clog2(SB) : 1;

  typedef enum logic [1:0] {F_IDLE, F_SQUARE, F_ROOT, F_PUSH} front_state_t;

  front_state_t     state;
  logic [SB-1:0]    abs_re;
  logic [SB-1:0]    abs_im;
  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [SB-1:0]    root;
  logic [CNT_W-1:0] cnt;

  logic [EXT_W-1:0] re_ext;
  logic [EXT_W-1:0] im_ext;
  logic [SB-1:0]    re_bits;
  logic [SB-1:0]    im_bits;
  logic [SB-1:0]    abs_re_next;
  logic [SB-1:0]    abs_im_next;
  logic [RAD_W-1:0] sq_sum;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             take;

  // low SAMPLE_BITS of each field, treated as two's complement
  assign re_ext  = EXT_W'($unsigned(re_sample));
  assign im_ext  = EXT_W'($unsigned(im_sample));
  assign re_bits = re_ext[SB-1:0];
  assign im_bits = im_ext[SB-1:0];
  assign abs_re_next = re_bits[SB-1] ? (~re_bits + 1'b1) : re_bits;
  assign abs_im_next = im_bits[SB-1] ? (~im_bits + 1'b1) : im_bits;

  // sum of squares, both products fit in RAD_W bits
  assign sq_sum = RAD_W'(abs_re) * RAD_W'(abs_re)
                + RAD_W'(abs_im) * RAD_W'(abs_im);

  // one result bit per cycle, two radicand bits brought down
  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root, 2'b01});
  assign take   = (rem_sh >= trial);

  assign in_ready = (state == F_IDLE) && !rst;
  assign push     = (state == F_PUSH) && !full;
  assign mag      = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            abs_re <= abs_re_next;
            abs_im <= abs_im_next;
            state  <= F_SQUARE;
          end
        end
        F_SQUARE: begin
          rad   <= sq_sum;
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= F_ROOT;
        end
        F_ROOT: begin
          rad <= rad << 2;
          if (take) begin
            rem  <= REM_W'(rem_sh - trial);
            root <= {root[SB-2:0], 1'b1};
          end else begin
            rem  <= REM_W'(rem_sh);
            root <= {root[SB-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SB - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/efpd_queue.sv -----
module efpd_queue
  import efpd_pkg::*;
#(
  parameter int WIDTH = SAMPLE_BITS_DEF,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/efpd_back.sv -----
module efpd_back
  import efpd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  efpd_cfg_t              cfg,
  input  logic                   empty,
  input  logic [SAMPLE_BITS-1:0] mag,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ENV_W-1:0]       envelope,
  output logic                   record_end,
  output logic [DUR_W-1:0]       pulse_duration
);

  localparam int SB     = SAMPLE_BITS;
  localparam int PA_W   = COEF_W + SB;
  localparam int PB_W   = COEF_W + ENV_W;
  localparam int ACC_W  = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
  localparam int FRAC_W = COEF_W;
  localparam int Y_W    = ACC_W - FRAC_W;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_ACC} back_state_t;

  back_state_t      state;
  logic [SB-1:0]    mag_q;
  logic [PA_W-1:0]  prod_a;
  logic [PB_W-1:0]  prod_b;
  logic [IDX_W-1:0] sample_index;
  logic [ENV_W-1:0] filter_value;
  logic [ENV_W-1:0] previous_envelope;
  logic [IDX_W-1:0] start_index;
  logic [IDX_W-1:0] stop_index;

  logic [ACC_W-1:0] acc;
  logic [Y_W-1:0]   y_wide;
  logic [ENV_W-1:0] y;
  logic [IDX_W-1:0] n_eff;
  logic             examine;
  logic [ENV_W-1:0] prev;
  logic [IDX_W-1:0] start_index_next;
  logic [IDX_W-1:0] stop_index_next;
  logic [ENV_W-1:0] previous_envelope_next;
  logic             last;
  logic [DUR_W-1:0] dur;

  assign pop = (state == B_IDLE) && !empty && !out_valid;

  // round half up, then saturate to the envelope range
  always_comb begin
    acc    = ACC_W'(prod_a) + ACC_W'(prod_b) + ROUND_HALF;
    y_wide = acc[ACC_W-1:FRAC_W];
    y      = (y_wide > Y_W'(ENV_MAX)) ? ENV_MAX : y_wide[ENV_W-1:0];
  end

  // edge detection inside the guard margins and end-of-record check
  always_comb begin
    n_eff   = (cfg.record_length == '0) ? IDX_W'(1) : cfg.record_length;
    examine = (sample_index >= IDX_W'(GUARD))
           && (({1'b0, sample_index} + (IDX_W + 1)'(GUARD)) < {1'b0, n_eff});
    prev    = (sample_index == IDX_W'(GUARD)) ? '0 : previous_envelope;
    start_index_next       = start_index;
    stop_index_next        = stop_index;
    previous_envelope_next = previous_envelope;
    if (examine) begin
      if (y > cfg.high_threshold && prev <= cfg.high_threshold) begin
        start_index_next = sample_index;
      end
      if (y < cfg.low_threshold && prev >= cfg.low_threshold) begin
        stop_index_next = sample_index;
      end
      previous_envelope_next = y;
    end
    last = (sample_index >= n_eff - 1'b1);
    dur  = last ? ({1'b0, stop_index_next} - {1'b0, start_index_next}) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= B_IDLE;
      out_valid         <= 1'b0;
      sample_index      <= '0;
      filter_value      <= '0;
      previous_envelope <= '0;
      start_index       <= '0;
      stop_index        <= '0;
    end else begin
      // output register drains on a transaction
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            mag_q <= mag;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod_a <= PA_W'(cfg.filter_gain) * PA_W'(mag_q);
          prod_b <= (sample_index == '0) ? '0
                  : PB_W'(cfg.filter_pole) * PB_W'(filter_value);
          state  <= B_ACC;
        end
        B_ACC: begin
          envelope       <= y;
          record_end     <= last;
          pulse_duration <= dur;
          out_valid      <= 1'b1;
          if (last) begin
            sample_index      <= '0;
            filter_value      <= '0;
            previous_envelope <= '0;
            start_index       <= '0;
            stop_index        <= '0;
          end else begin
            sample_index      <= sample_index + 1'b1;
            filter_value      <= y;
            previous_envelope <= previous_envelope_next;
            start_index       <= start_index_next;
            stop_index        <= stop_index_next;
          end
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import efpd_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TARGET_ITEMS = 1900;
  localparam int MAX_REPORTS  = 50;
  localparam int IDLE_CUSHION = 30;

  // indexes past the register list, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 3'd7;

  // one expected output transaction
  typedef struct packed {
    logic [ENV_W-1:0] envelope;
    logic             record_end;
    logic [DUR_W-1:0] duration;
  } envelope_result_t;

  // envelope filter and edge tracker model plus queue of expected outputs
  class envelope_tracker;
    efpd_cfg_t        cfg;
    logic [IDX_W-1:0] sample_idx;
    logic [ENV_W-1:0] filt_val;
    logic [ENV_W-1:0] prev_env;
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] stop_idx;
    envelope_result_t pending[$];
    int               errors;
    int               out_count;

    function new();
      cfg.filter_gain    = FILTER_GAIN_RST;
      cfg.filter_pole    = FILTER_POLE_RST;
      cfg.high_threshold = HIGH_THRESHOLD_RST;
      cfg.low_threshold  = LOW_THRESHOLD_RST;
      cfg.record_length  = RECORD_LENGTH_RST;
      clear_record();
      errors    = 0;
      out_count = 0;
    endfunction

    function void clear_record();
      sample_idx = '0;
      filt_val   = '0;
      prev_env   = '0;
      start_idx  = '0;
      stop_idx   = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FILTER_GAIN:    cfg.filter_gain    = data[COEF_W-1:0];
        CFG_FILTER_POLE:    cfg.filter_pole    = data[COEF_W-1:0];
        CFG_HIGH_THRESHOLD: cfg.high_threshold = data[ENV_W-1:0];
        CFG_LOW_THRESHOLD:  cfg.low_threshold  = data[ENV_W-1:0];
        CFG_RECORD_LENGTH:  cfg.record_length  = data[IDX_W-1:0];
        default: ;
      endcase
    endfunction

    // bit-pair integer square root
    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'h1 << 62;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
        if (x >= root + probe) begin
          x    = x - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root;
    endfunction

    // effective record length, zero counts as one
    function int unsigned record_len();
      return (cfg.record_length == 0) ? 1 : cfg.record_length;
    endfunction

    // accepted sample: advance the model and queue the expected output
    function void note_sample(logic signed [IN_W-1:0] re, logic signed [IN_W-1:0] im);
      longint signed    re_l;
      longint signed    im_l;
      longint unsigned  mag;
      longint unsigned  acc;
      int unsigned      n;
      int unsigned      i;
      logic [ENV_W-1:0] y;
      logic [ENV_W-1:0] prev;
      envelope_result_t res;
      re_l = re;
      im_l = im;
      mag  = int_sqrt(re_l * re_l + im_l * im_l);
      n    = record_len();
      i    = sample_idx;

      // one-pole low-pass, round half up, saturate
      acc = cfg.filter_gain * mag;
      if (i != 0) acc = acc + cfg.filter_pole * filt_val;
      acc = (acc + 64'd32768) >> 16;
      y = (acc > ENV_MAX) ? ENV_MAX : acc[ENV_W-1:0];
      filt_val = y;

      // edge tracking inside the guard margins
      if (i >= GUARD && i + GUARD < n) begin
        prev = (i == GUARD) ? '0 : prev_env;
        if (y > cfg.high_threshold && prev <= cfg.high_threshold) start_idx = i[IDX_W-1:0];
        if (y < cfg.low_threshold && prev >= cfg.low_threshold) stop_idx = i[IDX_W-1:0];
        prev_env = y;
      end

      res.envelope   = y;
      res.record_end = (i >= n - 1);
      res.duration   = '0;
      if (res.record_end) begin
        res.duration = DUR_W'(stop_idx) - DUR_W'(start_idx);
        clear_record();
      end else begin
        sample_idx = IDX_W'(i + 1);
      end
      pending.insert(pending.size(), res);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // accepted output: compare against the oldest expectation
    task check_output(logic [M_TDATA_W-1:0] tdata, logic tlast);
      envelope_result_t want;
      out_count++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("output %0d with nothing pending, tdata=%h tlast=%b",
                                  out_count, tdata, tlast));
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (tdata[ENV_W-1:0] !== want.envelope)
        report_mismatch($sformatf("output %0d envelope %0d, want %0d",
                                  out_count, tdata[ENV_W-1:0], want.envelope));
      if (tlast !== want.record_end)
        report_mismatch($sformatf("output %0d record end %b, want %b",
                                  out_count, tlast, want.record_end));
      if (tdata[ENV_W +: DUR_W] !== want.duration)
        report_mismatch($sformatf("output %0d pulse duration %0d, want %0d", out_count,
                                  $signed(tdata[ENV_W +: DUR_W]), $signed(want.duration)));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // re_sample[15:0], im_sample[31:16]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // envelope[17:0], pulse_duration[34:18]
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  envelope_tracker tracker;
  int              sent;
  bit              in_burst;
  bit              out_burst;
  int              level;
  int              win_lo;
  int              win_hi;
  int              rec_amp;
  int unsigned     cycle_count;

  envelope_filter_pulse_duration u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // one sample transaction, with a random lead-in gap outside bursts
  task automatic send_sample(input logic signed [IN_W-1:0] re,
                             input logic signed [IN_W-1:0] im);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {im, re};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    tracker.note_sample(re, im);
    sent++;
  endtask

  // hold off input until every pending output has come back
  task automatic wait_drained(input int cushion);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending.size() != 0);
    repeat (cushion) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    tracker.write_reg(idx, data);
  endtask

  task automatic write_all(input int gain, input int pole, input int hth, input int lth,
                           input int len);
    write_reg(CFG_FILTER_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_FILTER_POLE, CFG_DATA_W'(pole));
    write_reg(CFG_HIGH_THRESHOLD, CFG_DATA_W'(hth));
    write_reg(CFG_LOW_THRESHOLD, CFG_DATA_W'(lth));
    write_reg(CFG_RECORD_LENGTH, CFG_DATA_W'(len));
    write_reg(CFG_UNUSED_LAST, '1);
    cfg_valid <= 1'b0;
  endtask

  // random settings, 16-bit registers get junk in the upper data bits
  task automatic random_config();
    int pole;
    int gain;
    int hth;
    int lth;
    int len;
    case ($urandom_range(0, 7))
      0: pole = 0;
      1: pole = 65535;
      default: pole = $urandom_range(30000, 65000);
    endcase
    if ($urandom_range(0, 3) == 0) gain = $urandom_range(0, 65535);
    else gain = 65536 - pole + $urandom_range(0, 64) - 32;
    if (gain > 65535) gain = 65535;
    if (gain < 0) gain = 0;
    level = $urandom_range(1, 32767) >> $urandom_range(0, 12);
    hth = level;
    lth = level >> $urandom_range(0, 3);
    if ($urandom_range(0, 7) == 0) begin
      hth = $urandom_range(0, 262143);
      lth = $urandom_range(0, 262143);
    end
    case ($urandom_range(0, 19))
      14, 15:  len = $urandom_range(0, 20);
      16, 17:  len = $urandom_range(65, 300);
      18:      len = 1024;
      19:      len = 21;
      default: len = $urandom_range(21, 64);
    endcase
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_FILTER_GAIN, {2'($urandom_range(0, 3)), 16'(gain)});
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_FILTER_POLE, {2'($urandom_range(0, 3)), 16'(pole)});
    if ($urandom_range(0, 3) != 0) write_reg(CFG_HIGH_THRESHOLD, CFG_DATA_W'(hth));
    if ($urandom_range(0, 3) != 0) write_reg(CFG_LOW_THRESHOLD, CFG_DATA_W'(lth));
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_RECORD_LENGTH, {2'($urandom_range(0, 3)), 16'(len)});
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
  endtask

  // records with one pulse window over a low baseline, plus some noise
  task automatic send_shaped(input int count);
    int                      k;
    int                      idx;
    int                      n_eff;
    int                      amp;
    logic signed [IN_W-1:0]  re;
    logic signed [IN_W-1:0]  im;
    for (k = 0; k < count; k++) begin
      idx = tracker.sample_idx;
      if (idx == 0 || k == 0) begin
        n_eff   = tracker.record_len();
        if (n_eff > 200) n_eff = 200;
        win_lo  = $urandom_range(0, n_eff - 1);
        win_hi  = win_lo + $urandom_range(1, n_eff);
        rec_amp = level * $urandom_range(1, 4) / 2;
        if (rec_amp > 32767) rec_amp = 32767;
      end
      if ($urandom_range(0, 99) < 12) begin
        re = IN_W'($urandom);
        im = IN_W'($urandom);
      end else begin
        if (idx >= win_lo && idx < win_hi) begin
          re = IN_W'(rec_amp);
          im = IN_W'($urandom_range(0, rec_amp / 4));
        end else begin
          amp = $urandom_range(0, level / 8);
          re  = IN_W'(amp);
          im  = IN_W'($urandom_range(0, amp));
        end
        if ($urandom_range(0, 1) != 0) re = -re;
        if ($urandom_range(0, 1) != 0) im = -im;
      end
      if ($urandom_range(0, 199) == 0) wait_drained(0);
      send_sample(re, im);
    end
  endtask

  // output side: random stall before each transaction outside bursts
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      tracker.check_output(m_tdata, m_tlast);
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int corner_re [16];
    int corner_im [16];
    int k;
    corner_re = '{0, 32767, -32768, -32768, 32767, -1, 1, 0,
                  -32768, 21845, -21846, 255, -256, 3, 4, 32767};
    corner_im = '{0, 32767, -32768, 32767, -32768, -1, 0, -32768,
                  0, -21846, 21845, -256, 255, 4, -3, 0};
    tracker   = new();
    sent      = 0;
    in_burst  = 1'b0;
    out_burst = 1'b0;
    level     = 100;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: field extremes and bit patterns
    for (k = 0; k < 16; k++) send_sample(IN_W'(corner_re[k]), IN_W'(corner_im[k]));
    in_burst = 1'b1;
    send_shaped(8);
    in_burst = 1'b0;

    // shortest record, lowered while the record is past its end
    wait_drained(IDLE_CUSHION);
    write_all(65535, 0, 0, 262143, 21);
    level = 2000;
    send_shaped(60);

    // zero gain, full pole, zero length: every sample ends a record
    wait_drained(IDLE_CUSHION);
    write_all(0, 65535, 262143, 0, 0);
    send_shaped(20);

    // saturating filter on short records
    wait_drained(IDLE_CUSHION);
    write_all(65535, 65535, 262142, 262143, 20);
    level = 30000;
    send_shaped(60);

    // longest record setting
    wait_drained(IDLE_CUSHION);
    write_all(32768, 32768, 500, 100, 65535);
    level = 600;
    send_shaped(40);

    // length lowered mid-record
    wait_drained(IDLE_CUSHION);
    write_all(16384, 49152, 300, 40, 30);
    level = 400;
    send_shaped(90);

    // random settings and records
    while (sent < TARGET_ITEMS) begin
      wait_drained(IDLE_CUSHION);
      random_config();
      send_shaped($urandom_range(40, 160));
    end

    wait_drained(40);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- envelope_filter_pulse_duration.f -----
rtl/efpd_pkg.sv
rtl/efpd_front.sv
rtl/efpd_queue.sv
rtl/efpd_back.sv
rtl/envelope_filter_pulse_duration.sv
tb/tb.sv
